>>> sv/fdbo_pkg.sv
// ----------------------------------------------------------------------------
// fdbo_pkg
// Shared types, constants and helpers for the frame delta bounding-box block.
// ----------------------------------------------------------------------------
package fdbo_pkg;

    // frame geometry defaults
    localparam int unsigned DEF_MAX_WIDTH  = 256;
    localparam int unsigned DEF_MAX_HEIGHT = 256;

    // field widths fixed by the stream format
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned COORD_W    = 9;
    localparam int unsigned CHAN_W     = 2;
    localparam int unsigned STORE_W    = 3 * BYTE_W + 1;
    localparam int unsigned S_DATA_W   = 32;
    localparam int unsigned M_FIELDS_W = 1 + BYTE_W + 4 * COORD_W + 1;
    localparam int unsigned M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // opaque flag position inside the alpha byte
    localparam int unsigned OPAQUE_BIT = 7;

    // register reset values
    localparam logic [COORD_W-1:0] RST_FRAME_WIDTH  = COORD_W'(256);
    localparam logic [COORD_W-1:0] RST_FRAME_HEIGHT = COORD_W'(256);
    localparam logic [CHAN_W-1:0]  RST_CHANNELS     = CHAN_W'(3);

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH     = 2'd0,
        REG_FRAME_HEIGHT    = 2'd1,
        REG_COLOUR_CHANNELS = 2'd2
    } t_reg_idx;

    // one incoming pixel
    typedef struct packed {
        logic [BYTE_W-1:0] alpha;
        logic [BYTE_W-1:0] colour_c;
        logic [BYTE_W-1:0] colour_b;
        logic [BYTE_W-1:0] colour_a;
    } t_pixel;

    // position and frame markers of a pixel in flight
    typedef struct packed {
        logic               first;
        logic               done;
        logic               bottom;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_pix_ctl;

    // bounding box, right and bottom inclusive while tracking
    typedef struct packed {
        logic [COORD_W-1:0] bottom;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] left;
    } t_box;

    // one result beat
    typedef struct packed {
        logic               combine_ok;
        logic [COORD_W-1:0] box_bottom;
        logic [COORD_W-1:0] box_right;
        logic [COORD_W-1:0] box_top;
        logic [COORD_W-1:0] box_left;
        logic [BYTE_W-1:0]  optimized_alpha;
        logic               keep_pixel;
        logic               frame_done;
    } t_result;

    // grow a box to cover one position
    function automatic t_box box_add(input t_box b, input logic [COORD_W-1:0] x,
                                     input logic [COORD_W-1:0] y);
        t_box r;
        r = b;
        if (x < b.left)   r.left   = x;
        if (x > b.right)  r.right  = x;
        if (y < b.top)    r.top    = y;
        if (y > b.bottom) r.bottom = y;
        return r;
    endfunction

endpackage

>>> sv/fdbo_delta_unit.sv
// ----------------------------------------------------------------------------
// fdbo_delta_unit
// Compares a pixel with its stored predecessor, keeps the kept and opaque
// boxes, the combine flag and the bottom-frame flag, and forms the result.
// ----------------------------------------------------------------------------
module fdbo_delta_unit
    import fdbo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  t_pix_ctl           i_ctl,
    input  t_pixel             i_pix,
    input  logic [STORE_W-1:0] i_prev,
    input  logic [COORD_W-1:0] i_eff_w,
    input  logic [COORD_W-1:0] i_eff_h,
    input  logic [CHAN_W-1:0]  i_channels,
    output t_result            o_res
);

    t_box r_kept, n_kept;
    t_box r_opq, n_opq;
    logic r_combine, n_combine;
    logic r_frame_bottom, n_frame_bottom;

    t_box kept_base, opq_base, rep_box;
    logic combine_base;
    logic cur_op, prev_op, keep_d, opq_d, colour_diff;
    logic keep;

    // frame start reloads the boxes and the flags
    always_comb begin
        if (i_ctl.first) begin
            kept_base      = '{left: i_eff_w, top: i_eff_h, right: '0, bottom: '0};
            opq_base       = '{left: i_eff_w, top: i_eff_h, right: '0, bottom: '0};
            combine_base   = 1'b1;
            n_frame_bottom = i_ctl.bottom;
        end else begin
            kept_base      = r_kept;
            opq_base       = r_opq;
            combine_base   = r_combine;
            n_frame_bottom = r_frame_bottom;
        end
    end

    // delta decision against the stored pixel
    assign cur_op  = i_pix.alpha[OPAQUE_BIT];
    assign prev_op = i_prev[STORE_W-1];

    always_comb begin
        colour_diff = (i_pix.colour_a != i_prev[BYTE_W-1:0]);
        if (i_channels[1] && (i_pix.colour_b != i_prev[2*BYTE_W-1:BYTE_W]))
            colour_diff = 1'b1;
        if ((i_channels == CHAN_W'(3)) && (i_pix.colour_c != i_prev[3*BYTE_W-1:2*BYTE_W]))
            colour_diff = 1'b1;
    end

    always_comb begin
        keep_d    = 1'b0;
        opq_d     = 1'b0;
        n_combine = combine_base;
        case ({prev_op, cur_op})
            2'b00: begin
                keep_d = 1'b0;
                opq_d  = 1'b0;
            end
            2'b10: begin
                keep_d = 1'b1;
                opq_d  = 1'b0;
                if (!n_frame_bottom) n_combine = 1'b0;
            end
            2'b01: begin
                keep_d = 1'b1;
                opq_d  = 1'b1;
            end
            default: begin
                keep_d = colour_diff;
                opq_d  = 1'b1;
            end
        endcase
    end

    // box tracking, skipped for a bottom frame
    always_comb begin
        n_kept = kept_base;
        n_opq  = opq_base;
        if (!n_frame_bottom) begin
            if (opq_d)  n_opq  = box_add(opq_base, i_ctl.x, i_ctl.y);
            if (keep_d) n_kept = box_add(kept_base, i_ctl.x, i_ctl.y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept         <= '{left: RST_FRAME_WIDTH, top: RST_FRAME_HEIGHT,
                                right: '0, bottom: '0};
            r_opq          <= '{left: RST_FRAME_WIDTH, top: RST_FRAME_HEIGHT,
                                right: '0, bottom: '0};
            r_combine      <= 1'b1;
            r_frame_bottom <= 1'b0;
        end else if (i_go) begin
            r_kept         <= n_kept;
            r_opq          <= n_opq;
            r_combine      <= n_combine;
            r_frame_bottom <= n_frame_bottom;
        end
    end

    // result beat
    assign keep    = n_frame_bottom | keep_d;
    assign rep_box = n_combine ? n_kept : n_opq;

    always_comb begin
        o_res                 = '0;
        o_res.keep_pixel      = keep;
        o_res.optimized_alpha = keep ? i_pix.alpha : '0;
        o_res.frame_done      = i_ctl.done;
        if (i_ctl.done) begin
            if (n_frame_bottom) begin
                o_res.box_right  = i_eff_w;
                o_res.box_bottom = i_eff_h;
            end else begin
                o_res.box_left   = rep_box.left;
                o_res.box_top    = rep_box.top;
                o_res.box_right  = rep_box.right + COORD_W'(1);
                o_res.box_bottom = rep_box.bottom + COORD_W'(1);
                o_res.combine_ok = n_combine;
            end
        end
    end

endmodule

>>> sv/frame_delta_bbox_optimizer.sv
// ----------------------------------------------------------------------------
// frame_delta_bbox_optimizer
// Raster pixel stream against a previous-frame store; keeps changed pixels
// and reports the delta bounding box and combine flag at each frame end.
// ----------------------------------------------------------------------------
// An input beat passes the stage 1 registers, then the output register.
// Throughput: one pixel per cycle while the result side accepts, limited by
// the single read and single write port of the previous-frame store;
// back-to-back reuse of one entry (one-column one-row frames) is forwarded.
// Reset: counters to zero, boxes and flags to reload values; store contents
// stay undefined, no clearing pass is run; each frame writes all it covers.
// ----------------------------------------------------------------------------
module frame_delta_bbox_optimizer
    import fdbo_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: colour_a, colour_b, colour_c, alpha_in
    input  logic [S_DATA_W-1:0]   s_axis_tdata,
    // tuser: bottom_frame
    input  logic                  s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: keep_pixel, optimized_alpha, box_left, box_top, box_right,
    //        box_bottom, combine_ok, zero padding
    output logic [M_DATA_W-1:0]   m_axis_tdata,
    // tlast: frame_done
    output logic                  m_axis_tlast,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned CW0   = (XW > YW) ? XW : YW;
    localparam int unsigned CMP_W = ((CW0 > COORD_W) ? CW0 : COORD_W) + 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] r_frame_width, r_frame_height;
    logic [CHAN_W-1:0]  r_channels;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_channels     <= RST_CHANNELS;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_FRAME_WIDTH:     r_frame_width  <= pwdata[COORD_W-1:0];
                REG_FRAME_HEIGHT:    r_frame_height <= pwdata[COORD_W-1:0];
                REG_COLOUR_CHANNELS: r_channels     <= pwdata[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_FRAME_WIDTH:     prdata = APB_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT:    prdata = APB_DATA_W'(r_frame_height);
            REG_COLOUR_CHANNELS: prdata = APB_DATA_W'(r_channels);
            default:             prdata = '0;
        endcase
    end

    // effective geometry, zero acts as one and large values clamp
    logic [COORD_W-1:0] eff_w, eff_h;

    always_comb begin
        if (r_frame_width == '0)
            eff_w = COORD_W'(1);
        else if (CMP_W'(r_frame_width) > CMP_W'(MAX_WIDTH))
            eff_w = COORD_W'(MAX_WIDTH);
        else
            eff_w = r_frame_width;
        if (r_frame_height == '0)
            eff_h = COORD_W'(1);
        else if (CMP_W'(r_frame_height) > CMP_W'(MAX_HEIGHT))
            eff_h = COORD_W'(MAX_HEIGHT);
        else
            eff_h = r_frame_height;
    end

    // ------------------------------------------------------------------
    // handshake and raster counters
    // ------------------------------------------------------------------
    logic          r_s1_valid;
    logic          r_out_valid;
    logic          s1_go, in_acc;
    logic [XW-1:0] r_col, n_col;
    logic [YW-1:0] r_row, n_row;
    logic          col_wrap, row_wrap;
    logic [AW-1:0] rd_addr;

    assign s1_go         = r_s1_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_s1_valid | s1_go;
    assign in_acc        = s_axis_tvalid & s_axis_tready;

    assign col_wrap = (CMP_W'(r_col) + CMP_W'(1)) >= CMP_W'(eff_w);
    assign row_wrap = (CMP_W'(r_row) + CMP_W'(1)) >= CMP_W'(eff_h);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_wrap) begin
            n_col = '0;
            n_row = row_wrap ? '0 : YW'(CMP_W'(r_row) + CMP_W'(1));
        end else begin
            n_col = XW'(CMP_W'(r_col) + CMP_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign rd_addr = AW'(r_row) * AW'(MAX_WIDTH) + AW'(r_col);

    // ------------------------------------------------------------------
    // stage 1 registers: pixel, position, store address
    // ------------------------------------------------------------------
    t_pixel       r_s1_pix;
    t_pix_ctl     r_s1_ctl;
    logic [AW-1:0] r_s1_addr;
    logic [STORE_W-1:0] s1_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_s1_valid <= 1'b0;
        else if (in_acc)
            r_s1_valid <= 1'b1;
        else if (s1_go)
            r_s1_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix        <= t_pixel'(s_axis_tdata);
            r_s1_ctl.first  <= (r_col == '0) && (r_row == '0);
            r_s1_ctl.done   <= col_wrap & row_wrap;
            r_s1_ctl.bottom <= s_axis_tuser;
            r_s1_ctl.x      <= COORD_W'(r_col);
            r_s1_ctl.y      <= COORD_W'(r_row);
            r_s1_addr       <= rd_addr;
        end
    end

    assign s1_wdata = {r_s1_pix.alpha[OPAQUE_BIT], r_s1_pix.colour_c,
                       r_s1_pix.colour_b, r_s1_pix.colour_a};

    // ------------------------------------------------------------------
    // previous-frame store, read on accept, written back as stage 1 leaves
    // ------------------------------------------------------------------
    logic [STORE_W-1:0] mem [DEPTH];
    logic [STORE_W-1:0] r_rd_data;
    logic [STORE_W-1:0] r_fwd_data;
    logic               r_fwd_hit;
    logic [STORE_W-1:0] prev_word;

    always_ff @(posedge i_clk) begin
        if (in_acc)
            r_rd_data <= mem[rd_addr];
        if (s1_go)
            mem[r_s1_addr] <= s1_wdata;
    end

    // same entry written in the cycle it is read: take the new word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (in_acc) begin
            r_fwd_hit <= s1_go && (r_s1_addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc)
            r_fwd_data <= s1_wdata;
    end

    assign prev_word = r_fwd_hit ? r_fwd_data : r_rd_data;

    // ------------------------------------------------------------------
    // compare and box tracking
    // ------------------------------------------------------------------
    t_result s1_res;

    fdbo_delta_unit u_delta (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (s1_go),
        .i_ctl      (r_s1_ctl),
        .i_pix      (r_s1_pix),
        .i_prev     (prev_word),
        .i_eff_w    (eff_w),
        .i_eff_h    (eff_h),
        .i_channels (r_channels),
        .o_res      (s1_res)
    );

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [M_DATA_W-1:0] r_out_data;
    logic                r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (s1_go)
            r_out_valid <= 1'b1;
        else if (m_axis_tready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_data <= M_DATA_W'({s1_res.combine_ok, s1_res.box_bottom,
                                     s1_res.box_right, s1_res.box_top,
                                     s1_res.box_left, s1_res.optimized_alpha,
                                     s1_res.keep_pixel});
            r_out_last <= s1_res.frame_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

>>> sv/fdbo_checker.sv
// ----------------------------------------------------------------------------
// fdbo_checker
// Port-level checks on the frame delta bounding-box block, bound to the top.
// ----------------------------------------------------------------------------
module fdbo_checker
    import fdbo_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_DATA_W-1:0]   m_axis_tdata,
    input logic                  m_axis_tlast,
    input logic                  pready
);

    // result beat held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // no result beat straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // dropped pixels carry no alpha
    a_drop_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == '0)
        else $error("alpha on a dropped pixel");

    // box fields only on the last beat of a frame
    a_box_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[M_DATA_W-1:9] == '0)
        else $error("box fields set mid-frame");

    // configuration port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind frame_delta_bbox_optimizer fdbo_checker u_fdbo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for frame_delta_bbox_optimizer. Pixel beats go in
// raster order over the input stream, with random gaps on the send side and
// random stalls on the result side. A scoreboard keeps its own copy of the
// previous frame, counters, boxes and combine flag. For each accepted pixel
// it works out the result beat, and it compares every result beat with the
// oldest one still due. Register writes go over the configuration port and
// are read back.
// ----------------------------------------------------------------------------
module testbench
    import fdbo_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // scoreboard: own previous-frame copy, running boxes and due results
    class frame_delta_scoreboard;
        typedef struct packed {
            bit       keep;
            bit [7:0] alpha;
            bit       done;
            bit [8:0] left;
            bit [8:0] top;
            bit [8:0] right;
            bit [8:0] bottom;
            bit       comb;
        } t_verdict;

        bit [8:0]    cfg_width;
        bit [8:0]    cfg_height;
        bit [1:0]    cfg_channels;
        int unsigned col;
        int unsigned row;
        t_box        kept_box;
        t_box        opaque_box;
        bit          combine;
        bit          is_bottom;
        bit [24:0]   prev_pixel [65536];
        bit          written [65536];
        t_verdict    verdicts_due [$];
        int          mismatches;

        function new();
            cfg_width    = 9'd256;
            cfg_height   = 9'd256;
            cfg_channels = 2'd3;
            col          = 0;
            row          = 0;
            kept_box     = reload(256, 256);
            opaque_box   = reload(256, 256);
            combine      = 1'b1;
            is_bottom    = 1'b0;
            mismatches   = 0;
        endfunction

        // zero acts as one, anything above the maximum as the maximum
        function int unsigned span(bit [8:0] v);
            if (v == 0) return 1;
            if (v > 256) return 256;
            return v;
        endfunction

        function t_box reload(int unsigned w, int unsigned h);
            t_box b;
            b.left   = 9'(w);
            b.top    = 9'(h);
            b.right  = '0;
            b.bottom = '0;
            return b;
        endfunction

        function t_box grow(t_box b, int unsigned x, int unsigned y);
            if (9'(x) < b.left)   b.left   = 9'(x);
            if (9'(x) > b.right)  b.right  = 9'(x);
            if (9'(y) < b.top)    b.top    = 9'(y);
            if (9'(y) > b.bottom) b.bottom = 9'(y);
            return b;
        endfunction

        function void set_reg(t_reg_idx idx, bit [31:0] v);
            case (idx)
                REG_FRAME_WIDTH:     cfg_width    = v[8:0];
                REG_FRAME_HEIGHT:    cfg_height   = v[8:0];
                REG_COLOUR_CHANNELS: cfg_channels = v[1:0];
                default: ;
            endcase
        endfunction

        // every position of the coming frame already holds a pixel
        function bit region_ready();
            int unsigned w;
            int unsigned h;
            w = span(cfg_width);
            h = span(cfg_height);
            for (int unsigned y = 0; y < h; y++)
                for (int unsigned x = 0; x < w; x++)
                    if (!written[y * 256 + x]) return 1'b0;
            return 1'b1;
        endfunction

        function string show(t_verdict v);
            return $sformatf("keep=%0d alpha=%02h done=%0d box=(%0d,%0d,%0d,%0d) combine=%0d",
                             v.keep, v.alpha, v.done, v.left, v.top, v.right, v.bottom,
                             v.comb);
        endfunction

        function void complain(string msg);
            mismatches++;
            if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        // one accepted pixel beat: update state and queue its result
        function void note_pixel(bit [31:0] pix, bit bottom_flag);
            int unsigned w;
            int unsigned h;
            int unsigned ch;
            int unsigned idx;
            bit [24:0]   prev;
            bit          cur_op;
            bit          prev_op;
            bit          opq;
            bit          keep;
            bit          done;
            t_verdict    v;
            t_box        b;
            w      = span(cfg_width);
            h      = span(cfg_height);
            ch     = (cfg_channels == 0) ? 1 : cfg_channels;
            idx    = row * 256 + col;
            prev   = prev_pixel[idx];
            cur_op = pix[31];

            // frame start reloads the boxes and latches the bottom flag
            if (col == 0 && row == 0) begin
                kept_box   = reload(w, h);
                opaque_box = reload(w, h);
                combine    = 1'b1;
                is_bottom  = bottom_flag;
            end

            keep = 1'b1;
            opq  = 1'b0;
            if (!is_bottom) begin
                prev_op = prev[24];
                if (!cur_op && !prev_op) begin
                    keep = 1'b0;
                end else if (prev_op && !cur_op) begin
                    combine = 1'b0;
                end else if (!prev_op && cur_op) begin
                    opq = 1'b1;
                end else begin
                    opq  = 1'b1;
                    keep = pix[7:0] != prev[7:0];
                    if (ch >= 2 && pix[15:8] != prev[15:8]) keep = 1'b1;
                    if (ch >= 3 && pix[23:16] != prev[23:16]) keep = 1'b1;
                end
                if (opq) opaque_box = grow(opaque_box, col, row);
                if (keep) kept_box = grow(kept_box, col, row);
            end

            prev_pixel[idx] = {cur_op, pix[23:0]};
            written[idx]    = 1'b1;

            // raster position, register values apply at once
            done = 1'b0;
            if (col + 1 >= w) begin
                col = 0;
                if (row + 1 >= h) begin
                    row  = 0;
                    done = 1'b1;
                end else begin
                    row = row + 1;
                end
            end else begin
                col = col + 1;
            end

            v       = '0;
            v.keep  = keep;
            v.alpha = keep ? pix[31:24] : 8'd0;
            v.done  = done;
            if (done) begin
                if (is_bottom) begin
                    v.right  = 9'(w);
                    v.bottom = 9'(h);
                end else begin
                    b        = combine ? kept_box : opaque_box;
                    v.left   = b.left;
                    v.top    = b.top;
                    v.right  = b.right + 9'd1;
                    v.bottom = b.bottom + 9'd1;
                    v.comb   = combine;
                end
            end
            verdicts_due.push_back(v);
        endfunction

        // one accepted result beat against the oldest one due
        function void check_verdict(logic [M_DATA_W-1:0] d, logic last);
            t_verdict got;
            t_verdict exp;
            got.keep   = d[0];
            got.alpha  = d[8:1];
            got.left   = d[17:9];
            got.top    = d[26:18];
            got.right  = d[35:27];
            got.bottom = d[44:36];
            got.comb   = d[45];
            got.done   = last;
            if ($isunknown(d[45:0]) || $isunknown(last)) begin
                complain("unknown bits on a result beat");
            end
            if (verdicts_due.size() == 0) begin
                complain({"result beat with none due: ", show(got)});
                return;
            end
            exp = verdicts_due.pop_front();
            if (got != exp) complain({"expected ", show(exp), ", got ", show(got)});
        endfunction
    endclass

    typedef enum int {
        PX_SAME,
        PX_CHG_A,
        PX_CHG_B,
        PX_CHG_C,
        PX_CLEAR,
        PX_TO_OPAQUE,
        PX_RANDOM
    } t_pixel_kind;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // tdata: colour_a, colour_b, colour_c, alpha_in
    logic [S_DATA_W-1:0]   s_axis_tdata;
    // tuser: bottom_frame
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // tdata: keep_pixel, optimized_alpha, box_left, box_top, box_right,
    //        box_bottom, combine_ok, zero padding
    logic [M_DATA_W-1:0]   m_axis_tdata;
    // tlast: frame_done
    logic                  m_axis_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    frame_delta_scoreboard sb = new();
    int items_sent   = 0;
    bit calm         = 1'b0;
    bit sender_gappy = 1'b0;
    bit hold_req     = 1'b0;

    frame_delta_bbox_optimizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // result side: random stalls, one long hold-off on request
    always begin
        if (hold_req) begin
            m_axis_tready <= 1'b0;
            repeat (300) @(posedge i_clk);
            hold_req = 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end else begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    // result beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_verdict(m_axis_tdata, m_axis_tlast);
        end
    end

    // one pixel beat, held until accepted
    task automatic send_pixel(bit [31:0] pix, bit bottom_flag);
        if (!calm && sender_gappy && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= bottom_flag;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_pixel(pix, bottom_flag);
        items_sent++;
    endtask

    // stop offering and wait for every due result
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (sb.verdicts_due.size() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // register write then read back
    task automatic program_reg(t_reg_idx idx, bit [31:0] val);
        logic [APB_DATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== val) begin
            sb.complain($sformatf("register %s read back %h, written %h", idx.name(), rd, val));
        end
    endtask

    task automatic configure(bit [8:0] w, bit [8:0] h, bit [1:0] ch);
        program_reg(REG_FRAME_WIDTH, 32'(w));
        program_reg(REG_FRAME_HEIGHT, 32'(h));
        program_reg(REG_COLOUR_CHANNELS, 32'(ch));
    endtask

    // pixel derived from what the store holds at the current position
    function automatic bit [31:0] make_pixel(t_pixel_kind kind);
        bit [24:0] prev;
        bit [31:0] p;
        prev = sb.prev_pixel[sb.row * 256 + sb.col];
        p    = {prev[24], 7'($urandom), prev[23:0]};
        case (kind)
            PX_SAME: ;
            PX_CHG_A: begin
                p[31]    = 1'b1;
                p[7:0]   = p[7:0] ^ 8'($urandom_range(1, 255));
            end
            PX_CHG_B: begin
                p[31]    = 1'b1;
                p[15:8]  = p[15:8] ^ 8'($urandom_range(1, 255));
            end
            PX_CHG_C: begin
                p[31]    = 1'b1;
                p[23:16] = p[23:16] ^ 8'($urandom_range(1, 255));
            end
            PX_CLEAR: begin
                p[31]    = 1'b0;
                p[23:0]  = 24'($urandom);
            end
            PX_TO_OPAQUE: begin
                p[31]    = 1'b1;
                p[23:0]  = 24'($urandom);
            end
            default: p = $urandom;
        endcase
        return p;
    endfunction

    function automatic t_pixel_kind pick_kind(int rate);
        if ($urandom_range(0, 99) >= rate) return PX_SAME;
        case ($urandom_range(0, 5))
            0: return PX_CHG_A;
            1: return PX_CHG_B;
            2: return PX_CHG_C;
            3: return PX_CLEAR;
            4: return PX_TO_OPAQUE;
            default: return PX_RANDOM;
        endcase
    endfunction

    // pixels up to the frame end, or stop_after of them when nonzero;
    // a frame over unwritten positions is always sent as a bottom frame
    task automatic play_frame(int rate, bit want_bottom, int stop_after);
        bit          bot;
        bit          at_start;
        int          n;
        t_pixel_kind kind;
        n   = 0;
        bot = sb.is_bottom;
        do begin
            at_start = (sb.col == 0 && sb.row == 0);
            if (at_start) bot = want_bottom || !sb.region_ready();
            kind = bot ? PX_RANDOM : pick_kind(rate);
            send_pixel(make_pixel(kind), at_start ? bot : 1'($urandom));
            n++;
        end while (!(sb.col == 0 && sb.row == 0) && (stop_after == 0 || n < stop_after));
    endtask

    task automatic run_phase(bit [8:0] w, bit [8:0] h, bit [1:0] ch, int frames);
        int rate;
        wait_drained();
        configure(w, h, ch);
        sender_gappy = ($urandom_range(0, 2) != 0);
        repeat (frames) begin
            case ($urandom_range(0, 3))
                0: rate = 0;
                1: rate = 5;
                2: rate = 30;
                default: rate = 100;
            endcase
            play_frame(rate, $urandom_range(0, 9) == 0, 0);
        end
    endtask

    // mostly tiny extents, now and then zero or a little larger
    function automatic bit [8:0] pick_extent();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 9'd0;
        if (r < 16) return 9'($urandom_range(1, 8));
        return 9'($urandom_range(9, 24));
    endfunction

    bit [31:0] extremes [6] = '{32'h00000000, 32'hFFFFFFFF, 32'h80000000,
                                32'h7FFFFFFF, 32'h807F01FE, 32'hFF00FF00};
    t_pixel_kind crafted [6] = '{PX_TO_OPAQUE, PX_SAME, PX_CHG_C,
                                 PX_CLEAR, PX_CLEAR, PX_CHG_B};

    // main sequence
    initial begin
        bit [8:0]    w;
        bit [8:0]    h;
        int unsigned area;
        int          frames;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_rst_n       <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bottom frame of extreme values on a 3x2 frame
        configure(9'd3, 9'd2, 2'd3);
        for (int i = 0; i < 6; i++) send_pixel(extremes[i], i == 0);
        // every opacity transition, combine cleared
        for (int i = 0; i < 6; i++) send_pixel(make_pixel(crafted[i]), 1'b0);
        // nothing changes: empty box
        play_frame(0, 1'b0, 0);

        // one-pixel frames, zero registers acting as one
        wait_drained();
        configure(9'd0, 9'd0, 2'd0);
        play_frame(0, 1'b1, 0);
        send_pixel(make_pixel(PX_CHG_B), 1'b0);
        send_pixel(make_pixel(PX_CHG_A), 1'b0);

        // width shrinks in the middle of a frame
        wait_drained();
        configure(9'd3, 9'd2, 2'd2);
        play_frame(100, 1'b0, 4);
        wait_drained();
        program_reg(REG_FRAME_WIDTH, 32'd1);
        play_frame(50, 1'b0, 0);

        // widest and tallest frames, the first under a long result hold-off
        // that starts only once the block is empty, so the input side stalls
        wait_drained();
        hold_req = 1'b1;
        run_phase(9'd511, 9'd1, 2'd3, 2);
        run_phase(9'd1, 9'd300, 2'd1, 2);

        // random geometry, the tail without idling
        while (items_sent < 1650) begin
            calm   = items_sent >= 1400;
            w      = pick_extent();
            h      = pick_extent();
            area   = sb.span(w) * sb.span(h);
            frames = 120 / area;
            if (frames < 2) frames = 2;
            if (frames > 20) frames = 20;
            // keep the phase close to what is left of the item budget
            if (int'(area) * frames > 1650 - items_sent)
                frames = (1650 - items_sent) / int'(area) + 1;
            run_phase(w, h, 2'($urandom_range(0, 3)), frames);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.verdicts_due.size() != 0) begin
            sb.complain($sformatf("%0d results never arrived", sb.verdicts_due.size()));
        end
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
